FILE: src/assert_macros.svh
// Assertion macros for the RTL of the cooling tank program controller.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: src/ctpc_pkg.sv
// Types and constants of the cooling tank program controller.
// Used by the channel interfaces, the configuration registers and the top level.
`default_nettype none

package ctpc_pkg;

    localparam int TEMP_W     = 12;
    localparam int DELTA_W    = 9;
    localparam int SPAN_W     = 24;
    localparam int OP_W       = 3;
    localparam int STATE_W    = 4;
    localparam int RELAY_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 3'd0,
        OP_COOL = 3'd1,
        OP_MIX  = 3'd2,
        OP_ACID = 3'd3,
        OP_BASE = 3'd4,
        OP_DONE = 3'd5
    } op_t;

    typedef enum logic [STATE_W-1:0] {
        MODE_IDLE       = 4'd0,
        MODE_COOL_START = 4'd1,
        MODE_COOLING    = 4'd2,
        MODE_STORE      = 4'd3,
        MODE_MIX_START  = 4'd4,
        MODE_MIXING     = 4'd5,
        MODE_ACID_START = 4'd6,
        MODE_ACID_RUN   = 4'd7,
        MODE_ACID_DONE  = 4'd8,
        MODE_BASE_START = 4'd9,
        MODE_BASE_RUN   = 4'd10,
        MODE_BASE_DONE  = 4'd11
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COOL_SETPOINT = 3'd0,
        CFG_HYST_DELTA    = 3'd1,
        CFG_SAFE_MIN      = 3'd2,
        CFG_SAFE_MAX      = 3'd3,
        CFG_INITIAL_MIX   = 3'd4,
        CFG_MIXER_OFF     = 3'd5,
        CFG_MIXER_ON      = 3'd6
    } cfg_idx_t;

    localparam int RLY_COMP = 0;
    localparam int RLY_MIX  = 1;
    localparam int RLY_ACID = 2;
    localparam int RLY_BASE = 3;

    localparam logic [RELAY_W-1:0] RLY_COMP_M = 4'b0001;
    localparam logic [RELAY_W-1:0] RLY_MIX_M  = 4'b0010;
    localparam logic [RELAY_W-1:0] RLY_ACID_M = 4'b0100;
    localparam logic [RELAY_W-1:0] RLY_BASE_M = 4'b1000;

    localparam logic signed [TEMP_W-1:0] RST_COOL_SETPOINT = 12'sd40;
    localparam logic [DELTA_W-1:0]       RST_HYST_DELTA    = 9'd10;
    localparam logic signed [TEMP_W-1:0] RST_SAFE_MIN      = -12'sd100;
    localparam logic signed [TEMP_W-1:0] RST_SAFE_MAX      = 12'sd800;
    localparam logic [SPAN_W-1:0]        RST_INITIAL_MIX   = 24'd600;
    localparam logic [SPAN_W-1:0]        RST_MIXER_OFF     = 24'd1800;
    localparam logic [SPAN_W-1:0]        RST_MIXER_ON      = 24'd120;

    typedef struct packed {
        logic signed [TEMP_W-1:0] cool_setpoint;
        logic [DELTA_W-1:0]       hysteresis_delta;
        logic signed [TEMP_W-1:0] safe_temp_min;
        logic signed [TEMP_W-1:0] safe_temp_max;
        logic [SPAN_W-1:0]        initial_mix_ticks;
        logic [SPAN_W-1:0]        mixer_off_ticks;
        logic [SPAN_W-1:0]        mixer_on_ticks;
    } cfg_t;

endpackage

`default_nettype wire

FILE: src/ctpc_item_if.sv
// Input channel of the controller: op code and temperature with valid/ready.
// Depends on ctpc_pkg for field widths.
`default_nettype none

interface ctpc_item_if;
    logic                                 valid;
    logic                                 ready;
    logic [ctpc_pkg::OP_W-1:0]            op;
    logic signed [ctpc_pkg::TEMP_W-1:0]   temperature;

    modport source (output valid, output op, output temperature, input ready);
    modport sink   (input valid, input op, input temperature, output ready);
endinterface

`default_nettype wire

FILE: src/ctpc_result_if.sv
// Result channel of the controller: relay drives and program state with valid/ready.
// Depends on ctpc_pkg for field widths.
`default_nettype none

interface ctpc_result_if;
    logic                         valid;
    logic                         ready;
    logic                         compressor_on;
    logic                         mixer_on;
    logic                         acid_clean_on;
    logic                         base_clean_on;
    logic [ctpc_pkg::STATE_W-1:0] program_state;

    modport source (output valid, output compressor_on, output mixer_on,
                    output acid_clean_on, output base_clean_on, output program_state,
                    input ready);
    modport sink   (input valid, input compressor_on, input mixer_on,
                    input acid_clean_on, input base_clean_on, input program_state,
                    output ready);
endinterface

`default_nettype wire

FILE: src/ctpc_cfg_regs.sv
// Configuration register file of the controller, written through a plain write port.
// Depends on ctpc_pkg for the register layout and reset values.
`default_nettype none

module ctpc_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [ctpc_pkg::CFG_IDX_W-1:0]     index,
    input  wire logic [ctpc_pkg::CFG_DATA_W-1:0]    wdata,
    output      ctpc_pkg::cfg_t                     cfg
);

    ctpc_pkg::cfg_t cfg_reg;
    ctpc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                ctpc_pkg::CFG_COOL_SETPOINT:
                    cfg_next.cool_setpoint = wdata[ctpc_pkg::TEMP_W-1:0];
                ctpc_pkg::CFG_HYST_DELTA:
                    cfg_next.hysteresis_delta = wdata[ctpc_pkg::DELTA_W-1:0];
                ctpc_pkg::CFG_SAFE_MIN:
                    cfg_next.safe_temp_min = wdata[ctpc_pkg::TEMP_W-1:0];
                ctpc_pkg::CFG_SAFE_MAX:
                    cfg_next.safe_temp_max = wdata[ctpc_pkg::TEMP_W-1:0];
                ctpc_pkg::CFG_INITIAL_MIX:
                    cfg_next.initial_mix_ticks = wdata[ctpc_pkg::SPAN_W-1:0];
                ctpc_pkg::CFG_MIXER_OFF:
                    cfg_next.mixer_off_ticks = wdata[ctpc_pkg::SPAN_W-1:0];
                ctpc_pkg::CFG_MIXER_ON:
                    cfg_next.mixer_on_ticks = wdata[ctpc_pkg::SPAN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cool_setpoint     <= ctpc_pkg::RST_COOL_SETPOINT;
            cfg_reg.hysteresis_delta  <= ctpc_pkg::RST_HYST_DELTA;
            cfg_reg.safe_temp_min     <= ctpc_pkg::RST_SAFE_MIN;
            cfg_reg.safe_temp_max     <= ctpc_pkg::RST_SAFE_MAX;
            cfg_reg.initial_mix_ticks <= ctpc_pkg::RST_INITIAL_MIX;
            cfg_reg.mixer_off_ticks   <= ctpc_pkg::RST_MIXER_OFF;
            cfg_reg.mixer_on_ticks    <= ctpc_pkg::RST_MIXER_ON;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: src/cooling_tank_program_controller_top.sv
// Cooling tank program controller: an accepted input beat passes through the input
// register, then the result register, to its result beat; one beat per cycle
// is sustained while the result side takes every beat, set by the combinational
// mode and counter update between the two registers.
// Reset clears the mode to idle, the counters, the relays and the pending
// shutdown, and loads the configuration registers with their defaults.
`default_nettype none

`include "assert_macros.svh"

module cooling_tank_program_controller_top #(
    parameter int COUNTER_BITS = 24
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [ctpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ctpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    ctpc_item_if.sink                               item,
    ctpc_result_if.source                           result
);

    localparam int SPAN1_W = ctpc_pkg::SPAN_W + 1;
    localparam int PH_W    = (COUNTER_BITS > SPAN1_W) ? COUNTER_BITS : SPAN1_W;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    ctpc_pkg::cfg_t cfg;

    ctpc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    // input stage
    logic                                 s1_valid_reg;
    ctpc_pkg::op_t                        s1_op_reg;
    logic signed [ctpc_pkg::TEMP_W-1:0]   s1_temp_reg;

    // program state
    ctpc_pkg::mode_t                      mode_reg;
    ctpc_pkg::mode_t                      mode_next;
    logic [COUNTER_BITS-1:0]              ticks_reg;
    logic [COUNTER_BITS-1:0]              ticks_next;
    logic [COUNTER_BITS-1:0]              phase_reg;
    logic [COUNTER_BITS-1:0]              phase_next;
    logic [ctpc_pkg::RELAY_W-1:0]         relay_reg;
    logic [ctpc_pkg::RELAY_W-1:0]         relay_next;
    logic                                 pend_reg;
    logic                                 pend_next;

    // result stage
    logic                                 res_valid_reg;
    logic [ctpc_pkg::RELAY_W-1:0]         res_relay_reg;
    ctpc_pkg::mode_t                      res_mode_reg;

    logic stage_adv;
    logic item_acc;

    assign stage_adv  = s1_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || stage_adv;
    assign item_acc   = item.valid && item.ready;

    // control from the current beat
    logic                          enter_mode;
    logic                          cold_start;
    logic                          count_en;
    logic                          store_mix;
    logic                          shut_off;
    logic                          stop_prog;
    logic [ctpc_pkg::RELAY_W-1:0]  relay_set;
    logic [ctpc_pkg::RELAY_W-1:0]  relay_clr;

    logic signed [ctpc_pkg::TEMP_W-1:0]   tgt_s;
    logic signed [ctpc_pkg::TEMP_W-1:0]   tmin_s;
    logic signed [ctpc_pkg::TEMP_W-1:0]   tmax_s;
    logic signed [ctpc_pkg::TEMP_W+1:0]   hyst_lim;
    logic                                 cold;
    logic                                 restart;

    logic [PH_W-1:0]               period_w;
    logic [PH_W-1:0]               init_w;
    logic [PH_W-1:0]               init_p1;
    logic [COUNTER_BITS-1:0]       sat_init;
    logic [COUNTER_BITS-1:0]       phase_one;
    logic [COUNTER_BITS-1:0]       ticks_a;
    logic [COUNTER_BITS-1:0]       phase_a;
    logic                          mix_want;

    function automatic logic [COUNTER_BITS-1:0] next_phase(
        input logic [COUNTER_BITS-1:0] p,
        input logic [PH_W-1:0]         period
    );
        logic [COUNTER_BITS-1:0] n;
        n = p + 1'b1;
        if (PH_W'(n) >= period)
            return '0;
        return n;
    endfunction

    assign tgt_s    = cfg.cool_setpoint;
    assign tmin_s   = cfg.safe_temp_min;
    assign tmax_s   = cfg.safe_temp_max;
    assign hyst_lim = (ctpc_pkg::TEMP_W+2)'(tgt_s)
                    + (ctpc_pkg::TEMP_W+2)'($signed({1'b0, cfg.hysteresis_delta}));
    assign cold     = (s1_temp_reg > tmin_s) && (s1_temp_reg <= tgt_s);
    assign restart  = (s1_temp_reg < tmax_s)
                   && ((ctpc_pkg::TEMP_W+2)'(s1_temp_reg) > hyst_lim);

    assign period_w  = PH_W'(cfg.mixer_off_ticks) + PH_W'(cfg.mixer_on_ticks);
    assign init_w    = PH_W'(cfg.initial_mix_ticks);
    assign init_p1   = init_w + 1'b1;
    assign sat_init  = (init_p1 > PH_W'(CNT_MAX)) ? CNT_MAX : init_p1[COUNTER_BITS-1:0];
    assign phase_one = (period_w <= PH_W'(1)) ? '0 : COUNTER_BITS'(1);
    assign mix_want  = (PH_W'(ticks_reg) < init_w)
                    || (PH_W'(phase_reg) >= PH_W'(cfg.mixer_off_ticks));

    // next mode and actions
    always_comb
    begin
        mode_next  = mode_reg;
        enter_mode = 1'b0;
        cold_start = 1'b0;
        count_en   = 1'b0;
        store_mix  = 1'b0;
        shut_off   = 1'b0;
        stop_prog  = 1'b0;
        relay_set  = '0;
        relay_clr  = '0;
        unique case (s1_op_reg)
            ctpc_pkg::OP_TICK:
            begin
                unique case (mode_reg)
                    ctpc_pkg::MODE_COOL_START:
                    begin
                        count_en   = 1'b1;
                        enter_mode = 1'b1;
                        if (cold)
                        begin
                            mode_next  = ctpc_pkg::MODE_STORE;
                            cold_start = 1'b1;
                        end
                        else
                        begin
                            mode_next = ctpc_pkg::MODE_COOLING;
                            relay_set = ctpc_pkg::RLY_COMP_M | ctpc_pkg::RLY_MIX_M;
                        end
                    end
                    ctpc_pkg::MODE_COOLING:
                    begin
                        if (cold)
                        begin
                            mode_next  = ctpc_pkg::MODE_STORE;
                            enter_mode = 1'b1;
                        end
                        else
                        begin
                            relay_set = ctpc_pkg::RLY_COMP_M | ctpc_pkg::RLY_MIX_M;
                            count_en  = 1'b1;
                        end
                    end
                    ctpc_pkg::MODE_STORE:
                    begin
                        if (restart)
                        begin
                            mode_next  = ctpc_pkg::MODE_COOLING;
                            enter_mode = 1'b1;
                        end
                        else
                        begin
                            store_mix = 1'b1;
                            count_en  = 1'b1;
                        end
                    end
                    ctpc_pkg::MODE_MIX_START:
                    begin
                        relay_set  = ctpc_pkg::RLY_MIX_M;
                        mode_next  = ctpc_pkg::MODE_MIXING;
                        enter_mode = 1'b1;
                        count_en   = 1'b1;
                    end
                    ctpc_pkg::MODE_MIXING:
                    begin
                        relay_set = ctpc_pkg::RLY_MIX_M;
                        count_en  = 1'b1;
                    end
                    ctpc_pkg::MODE_ACID_START:
                    begin
                        relay_set  = ctpc_pkg::RLY_ACID_M;
                        mode_next  = ctpc_pkg::MODE_ACID_RUN;
                        enter_mode = 1'b1;
                        count_en   = 1'b1;
                    end
                    ctpc_pkg::MODE_BASE_START:
                    begin
                        relay_set  = ctpc_pkg::RLY_BASE_M;
                        mode_next  = ctpc_pkg::MODE_BASE_RUN;
                        enter_mode = 1'b1;
                        count_en   = 1'b1;
                    end
                    ctpc_pkg::MODE_ACID_RUN, ctpc_pkg::MODE_ACID_DONE,
                    ctpc_pkg::MODE_BASE_RUN, ctpc_pkg::MODE_BASE_DONE:
                        count_en = 1'b1;
                    default:
                        shut_off = pend_reg;
                endcase
            end
            ctpc_pkg::OP_COOL:
            begin
                if (mode_reg == ctpc_pkg::MODE_IDLE)
                begin
                    mode_next  = ctpc_pkg::MODE_COOL_START;
                    enter_mode = 1'b1;
                end
                else if (mode_reg == ctpc_pkg::MODE_COOLING || mode_reg == ctpc_pkg::MODE_STORE)
                begin
                    stop_prog = 1'b1;
                end
            end
            ctpc_pkg::OP_MIX:
            begin
                if (mode_reg == ctpc_pkg::MODE_IDLE)
                begin
                    mode_next  = ctpc_pkg::MODE_MIX_START;
                    enter_mode = 1'b1;
                end
                else if (mode_reg == ctpc_pkg::MODE_MIXING)
                begin
                    stop_prog = 1'b1;
                end
            end
            ctpc_pkg::OP_ACID:
            begin
                if (mode_reg == ctpc_pkg::MODE_IDLE)
                begin
                    mode_next  = ctpc_pkg::MODE_ACID_START;
                    enter_mode = 1'b1;
                end
                else if (mode_reg == ctpc_pkg::MODE_ACID_RUN
                      || mode_reg == ctpc_pkg::MODE_ACID_DONE)
                begin
                    stop_prog = 1'b1;
                end
            end
            ctpc_pkg::OP_BASE:
            begin
                if (mode_reg == ctpc_pkg::MODE_IDLE)
                begin
                    mode_next  = ctpc_pkg::MODE_BASE_START;
                    enter_mode = 1'b1;
                end
                else if (mode_reg == ctpc_pkg::MODE_BASE_RUN
                      || mode_reg == ctpc_pkg::MODE_BASE_DONE)
                begin
                    stop_prog = 1'b1;
                end
            end
            ctpc_pkg::OP_DONE:
            begin
                if (mode_reg == ctpc_pkg::MODE_ACID_RUN)
                begin
                    mode_next  = ctpc_pkg::MODE_ACID_DONE;
                    enter_mode = 1'b1;
                    relay_clr  = ctpc_pkg::RLY_ACID_M;
                end
                else if (mode_reg == ctpc_pkg::MODE_BASE_RUN)
                begin
                    mode_next  = ctpc_pkg::MODE_BASE_DONE;
                    enter_mode = 1'b1;
                    relay_clr  = ctpc_pkg::RLY_BASE_M;
                end
            end
            default:
                mode_next = mode_reg;
        endcase
        if (stop_prog)
        begin
            mode_next  = ctpc_pkg::MODE_IDLE;
            enter_mode = 1'b1;
        end
    end

    // counters, relays and shutdown flag
    always_comb
    begin
        ticks_a = enter_mode ? '0 : ticks_reg;
        phase_a = enter_mode ? '0 : phase_reg;
        if (cold_start)
        begin
            ticks_a = sat_init;
            phase_a = phase_one;
        end

        ticks_next = ticks_a;
        phase_next = phase_a;
        if (count_en)
        begin
            phase_next = (PH_W'(ticks_a) < init_w) ? '0 : next_phase(phase_a, period_w);
            ticks_next = (ticks_a != CNT_MAX) ? ticks_a + 1'b1 : ticks_a;
        end

        relay_next = (relay_reg | relay_set) & ~relay_clr;
        if (store_mix)
        begin
            relay_next[ctpc_pkg::RLY_COMP] = 1'b0;
            relay_next[ctpc_pkg::RLY_MIX]  = mix_want;
        end
        if (shut_off)
            relay_next = '0;

        pend_next = pend_reg;
        if (stop_prog)
            pend_next = 1'b1;
        else if (shut_off)
            pend_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            mode_reg      <= ctpc_pkg::MODE_IDLE;
            ticks_reg     <= '0;
            phase_reg     <= '0;
            relay_reg     <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (item_acc)
                s1_valid_reg <= 1'b1;
            else if (stage_adv)
                s1_valid_reg <= 1'b0;

            if (stage_adv)
            begin
                res_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                ticks_reg     <= ticks_next;
                phase_reg     <= phase_next;
                relay_reg     <= relay_next;
                pend_reg      <= pend_next;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            s1_op_reg   <= ctpc_pkg::op_t'(item.op);
            s1_temp_reg <= item.temperature;
        end
        if (stage_adv)
        begin
            res_relay_reg <= relay_next;
            res_mode_reg  <= mode_next;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.compressor_on = res_relay_reg[ctpc_pkg::RLY_COMP];
    assign result.mixer_on      = res_relay_reg[ctpc_pkg::RLY_MIX];
    assign result.acid_clean_on = res_relay_reg[ctpc_pkg::RLY_ACID];
    assign result.base_clean_on = res_relay_reg[ctpc_pkg::RLY_BASE];
    assign result.program_state = res_mode_reg;

    logic chk_cool_tick;
    logic chk_cool_kept;
    logic chk_acid_done;
    logic chk_acid_clear;

    assign chk_cool_tick  = stage_adv && s1_op_reg == ctpc_pkg::OP_TICK
                         && mode_reg == ctpc_pkg::MODE_COOLING;
    assign chk_cool_kept  = relay_reg[ctpc_pkg::RLY_COMP] || mode_reg == ctpc_pkg::MODE_STORE;
    assign chk_acid_done  = stage_adv && s1_op_reg == ctpc_pkg::OP_DONE
                         && mode_reg == ctpc_pkg::MODE_ACID_RUN;
    assign chk_acid_clear = mode_reg == ctpc_pkg::MODE_ACID_DONE
                         && !relay_reg[ctpc_pkg::RLY_ACID];

    `ASSERT_NEXT(a_adv_fills_result, clk, rst_n, stage_adv, res_valid_reg)
    `ASSERT_NEXT(a_cooling_tick, clk, rst_n, chk_cool_tick, chk_cool_kept)
    `ASSERT_NEXT(a_acid_done, clk, rst_n, chk_acid_done, chk_acid_clear)

endmodule

`default_nettype wire
